>>> src/bcb_pkg.sv
// ----------------------------------------------------------------------------
// bcb_pkg
// Shared codes, character constants and the bitmap command type for the
// bracket class builder and matcher.
// ----------------------------------------------------------------------------
package bcb_pkg;

	localparam int CharWidth = 7;
	localparam int MapBits   = 1 << CharWidth;
	localparam int StatWidth = 3;

	// Characters with meaning inside a bracket expression
	localparam logic [CharWidth-1:0] ChOpen  = 7'h5B; // '['
	localparam logic [CharWidth-1:0] ChClose = 7'h5D; // ']'
	localparam logic [CharWidth-1:0] ChCaret = 7'h5E; // '^'
	localparam logic [CharWidth-1:0] ChDash  = 7'h2D; // '-'
	localparam logic [CharWidth-1:0] ChEnd   = 7'h00; // end of string

	// Operation codes
	localparam logic OpPattern = 1'b0;
	localparam logic OpQuery   = 1'b1;

	// Result status codes
	localparam logic [StatWidth-1:0] StOk     = 3'd0;
	localparam logic [StatWidth-1:0] StDone   = 3'd1;
	localparam logic [StatWidth-1:0] StNoOpen = 3'd2;
	localparam logic [StatWidth-1:0] StLDash  = 3'd3;
	localparam logic [StatWidth-1:0] StTDash  = 3'd4;
	localparam logic [StatWidth-1:0] StBadRng = 3'd5;
	localparam logic [StatWidth-1:0] StUnterm = 3'd6;

	// Update to the membership bitmap, issued by the parser
	typedef struct packed {
		logic                 clr;  // clear the whole map
		logic                 fill; // set every code from lo to hi
		logic                 inv;  // invert the whole map
		logic [CharWidth-1:0] lo;
		logic [CharWidth-1:0] hi;
	} bcb_cmd_t;

endpackage

>>> src/bcb_class_map.sv
// ----------------------------------------------------------------------------
// bcb_class_map
// 128-bit membership bitmap: clear, span fill, invert, and the query read.
// ----------------------------------------------------------------------------
module bcb_class_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bcb_pkg::bcb_cmd_t             cmd,
	input  logic [bcb_pkg::CharWidth-1:0] query_char,
	output logic                          member
);

	logic [bcb_pkg::MapBits-1:0] map_q;
	logic [bcb_pkg::MapBits-1:0] span_mask;

	// One compare pair per code, all in parallel
	always_comb begin
		for (int i = 0; i < bcb_pkg::MapBits; i++) begin
			span_mask[i] = (bcb_pkg::CharWidth'(i) >= cmd.lo) &&
				(bcb_pkg::CharWidth'(i) <= cmd.hi);
		end
	end

	// Map update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (cmd.clr) begin
			map_q <= '0;
		end else if (cmd.inv) begin
			map_q <= ~map_q;
		end else if (cmd.fill) begin
			map_q <= map_q | span_mask;
		end
	end

	assign member = map_q[query_char];

endmodule

>>> src/bcb_parser.sv
// ----------------------------------------------------------------------------
// bcb_parser
// Bracket expression parse state and per-item next-state logic.
// ----------------------------------------------------------------------------
module bcb_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          op,
	input  logic [bcb_pkg::CharWidth-1:0] ch,
	output logic [bcb_pkg::StatWidth-1:0] status,
	output logic                          ready_next,
	output bcb_pkg::bcb_cmd_t             cmd
);

	localparam logic [2:0] PhOpen  = 3'd0;
	localparam logic [2:0] PhFirst = 3'd1;
	localparam logic [2:0] PhCaret = 3'd2;
	localparam logic [2:0] PhBody  = 3'd3;
	localparam logic [2:0] PhDash  = 3'd4;

	logic [2:0]                    phase_q, phase_d;
	logic [bcb_pkg::CharWidth-1:0] prev_q, prev_d;
	logic                          inv_q, inv_d;
	logic                          ready_q, ready_d;
	logic [bcb_pkg::StatWidth-1:0] st;
	bcb_pkg::bcb_cmd_t             cmd_d;

	// Next state for one pattern character
	always_comb begin
		phase_d    = phase_q;
		prev_d     = prev_q;
		inv_d      = inv_q;
		ready_d    = ready_q;
		st         = bcb_pkg::StOk;
		cmd_d      = '0;
		cmd_d.lo   = ch;
		cmd_d.hi   = ch;
		if (op == bcb_pkg::OpPattern) begin
			case (phase_q)
				PhFirst, PhCaret, PhBody: begin
					if (phase_q == PhFirst && ch == bcb_pkg::ChCaret) begin
						inv_d   = 1'b1;
						phase_d = PhCaret;
					end else if (phase_q != PhBody && ch == bcb_pkg::ChDash) begin
						st      = bcb_pkg::StLDash;
						phase_d = PhOpen;
					end else if (ch == bcb_pkg::ChClose) begin
						// close: apply pending inversion
						cmd_d.inv = inv_q;
						ready_d   = 1'b1;
						st        = bcb_pkg::StDone;
						phase_d   = PhOpen;
					end else if (ch == bcb_pkg::ChEnd) begin
						st      = bcb_pkg::StUnterm;
						phase_d = PhOpen;
					end else if (ch == bcb_pkg::ChDash) begin
						phase_d = PhDash;
					end else begin
						cmd_d.fill = 1'b1;
						prev_d     = ch;
						phase_d    = PhBody;
					end
				end
				PhDash: begin
					if (ch == bcb_pkg::ChEnd || ch == bcb_pkg::ChClose) begin
						st      = bcb_pkg::StTDash;
						phase_d = PhOpen;
					end else if (prev_q > ch) begin
						st      = bcb_pkg::StBadRng;
						phase_d = PhOpen;
					end else begin
						cmd_d.fill = 1'b1;
						cmd_d.lo   = prev_q;
						prev_d     = ch;
						phase_d    = PhBody;
					end
				end
				default: begin
					// waiting for the opening bracket
					phase_d = PhOpen;
					if (ch != bcb_pkg::ChOpen) begin
						st = bcb_pkg::StNoOpen;
					end else begin
						cmd_d.clr = 1'b1;
						inv_d     = 1'b0;
						ready_d   = 1'b0;
						prev_d    = '0;
						phase_d   = PhFirst;
					end
				end
			endcase
		end
	end

	// State registers, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhOpen;
			prev_q  <= '0;
			inv_q   <= 1'b0;
			ready_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			prev_q  <= prev_d;
			inv_q   <= inv_d;
			ready_q <= ready_d;
		end
	end

	assign status     = st;
	assign ready_next = ready_d;

	// Map commands only go out with an item
	always_comb begin
		cmd      = cmd_d;
		cmd.clr  = cmd_d.clr & step;
		cmd.fill = cmd_d.fill & step;
		cmd.inv  = cmd_d.inv & step;
	end

`ifndef NO_ASSERTIONS
	a_ready_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(step && st == bcb_pkg::StDone))
		else $error("set ready rose without a closing bracket");
	a_query_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		step && op == bcb_pkg::OpQuery |=> $stable(phase_q) && $stable(prev_q))
		else $error("query changed the parse state");
	a_error_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		step && (st == bcb_pkg::StLDash || st == bcb_pkg::StTDash ||
		st == bcb_pkg::StBadRng || st == bcb_pkg::StUnterm) |=> phase_q == PhOpen)
		else $error("parser did not return to waiting for the bracket");
`endif

endmodule

>>> src/bracket_class_builder_matcher.sv
// ----------------------------------------------------------------------------
// bracket_class_builder_matcher
// Builds a character class from a bracket expression and answers queries.
// ----------------------------------------------------------------------------
// One item is taken every clock while the input is not stalled, and each item
// gives exactly one result item. An item goes through an input register and a
// result register, and its result is offered from the result register. The
// parse step and the bitmap update (a parallel per-code range compare over all
// 128 codes) are done in the single stage between those registers. A result
// that is not taken stalls the input only once both registers are full. The
// bitmap resets to empty, so no clearing pass is needed after reset.
module bracket_class_builder_matcher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [bcb_pkg::CharWidth-1:0] char_code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bcb_pkg::StatWidth-1:0] status,
	output logic                          is_member,
	output logic                          set_ready
);

	logic                          valid_s1;
	logic                          op_s1;
	logic [bcb_pkg::CharWidth-1:0] char_s1;
	logic                          out_valid_q;
	logic [bcb_pkg::StatWidth-1:0] status_q;
	logic                          member_q;
	logic                          ready_q;
	logic                          advance;
	logic [bcb_pkg::StatWidth-1:0] st_c;
	logic                          ready_c;
	logic                          member_c;
	bcb_pkg::bcb_cmd_t             cmd;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			char_s1 <= char_code;
		end
	end

	bcb_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.op         (op_s1),
		.ch         (char_s1),
		.status     (st_c),
		.ready_next (ready_c),
		.cmd        (cmd)
	);

	bcb_class_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.query_char (char_s1),
		.member     (member_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= st_c;
			member_q <= (op_s1 == bcb_pkg::OpQuery) ? member_c : 1'b0;
			ready_q  <= ready_c;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign is_member = member_q;
	assign set_ready = ready_q;

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled with room in the pipeline");
	a_query_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == bcb_pkg::OpQuery |=> status_q == bcb_pkg::StOk)
		else $error("query item gave a nonzero status");
	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item produced no result");
`endif

endmodule
